// File: src/mi3_pkg.sv
// Shared types and constants for the 3x3 matrix inverse pipeline.
// No dependencies; every other file of the block imports this package.
package mi3_pkg;

   localparam int ELEM_W = 32;
   localparam int COF_W  = 64;
   localparam int DET_W  = 97;
   localparam int DMAG_W = 96;
   localparam int QUO_W  = 32;
   localparam int N_ELEM = 9;
   localparam int N_TERM = 3;

   localparam logic [ELEM_W-1:0] SAT_POS = 32'h7FFF_FFFF;
   localparam logic [ELEM_W-1:0] SAT_NEG = 32'h8000_0000;

   typedef logic signed [ELEM_W-1:0] elem_type;
   typedef logic [DMAG_W-1:0] dmag_type;

   // Cofactor i is m[PA]*m[PB] - m[PC]*m[PD], elements in row-major order.
   localparam int COF_PA [N_ELEM] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
   localparam int COF_PB [N_ELEM] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
   localparam int COF_PC [N_ELEM] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
   localparam int COF_PD [N_ELEM] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

   // Hand-off from the determinant stages to the divider pipeline.
   typedef struct packed {
      logic [N_ELEM-1:0][COF_W-1:0] amag;
      logic [N_ELEM-1:0]            aneg;
      logic [N_ELEM-1:0]            azero;
      dmag_type                     dmag;
      logic                         dneg;
      logic                         singular;
   } div_in_type;

endpackage

// File: src/mi3_req_if.sv
// Request and response channel interfaces for the matrix inverse.
// Depends on mi3_pkg for the element type.
interface mi3_req_if;
   import mi3_pkg::*;
   logic     valid;
   logic     ready;
   elem_type m00, m01, m02, m10, m11, m12, m20, m21, m22;
   modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                   input ready);
   modport sink (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                 output ready);
endinterface

interface mi3_rsp_if;
   import mi3_pkg::*;
   logic     valid;
   logic     ready;
   elem_type v00, v01, v02, v10, v11, v12, v20, v21, v22;
   logic     singular;
   modport source (output valid, v00, v01, v02, v10, v11, v12, v20, v21, v22,
                   singular, input ready);
   modport sink (input valid, v00, v01, v02, v10, v11, v12, v20, v21, v22,
                 singular, output ready);
endinterface

// File: src/mi3_div.sv
// Pipelined divider: nine restoring-division lanes, one quotient bit per stage,
// with saturation into the response register. Depends on mi3_pkg, mi3_rsp_if.
module mi3_div (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  mi3_pkg::div_in_type in_data,
   mi3_rsp_if.source           rsp_chan
);
   import mi3_pkg::*;

   typedef struct packed {
      dmag_type         rem;
      logic [QUO_W-1:0] quo;
      logic             ovf;
      logic             neg;
      logic             zero;
   } lane_type;

   typedef struct packed {
      lane_type [N_ELEM-1:0] lane;
      dmag_type              dmag;
      logic                  singular;
   } step_type;

   step_type    st_ff [QUO_W+1];
   step_type    st_in [QUO_W+1];
   logic [QUO_W:0] vld_ff, vld_in, rdy;
   logic        out_vld_ff, out_vld_in, out_rdy;
   elem_type    out_ff [N_ELEM];
   elem_type    out_in [N_ELEM];
   logic        sing_ff, sing_in;

   // Each stage moves when it is empty or the next one moves.
   always_comb begin
      out_rdy = !out_vld_ff || rsp_chan.ready;
      rdy[QUO_W] = !vld_ff[QUO_W] || out_rdy;
      for (int k = QUO_W - 1; k >= 0; k--) begin
         rdy[k] = !vld_ff[k] || rdy[k+1];
      end
      vld_in[0] = in_valid;
      for (int k = 1; k <= QUO_W; k++) begin
         vld_in[k] = vld_ff[k-1];
      end
      out_vld_in = vld_ff[QUO_W];
   end
   assign in_ready = rdy[0];

   // Setup stage: a cofactor not below the divisor overflows the quotient.
   always_comb begin
      st_in[0].dmag = in_data.dmag;
      st_in[0].singular = in_data.singular;
      for (int i = 0; i < N_ELEM; i++) begin
         st_in[0].lane[i].rem  = DMAG_W'(in_data.amag[i]);
         st_in[0].lane[i].quo  = '0;
         st_in[0].lane[i].ovf  = DMAG_W'(in_data.amag[i]) >= in_data.dmag;
         st_in[0].lane[i].neg  = in_data.aneg[i] ^ in_data.dneg;
         st_in[0].lane[i].zero = in_data.azero[i];
      end
   end

   // Division steps: doubled remainder against the divisor.
   for (genvar k = 1; k <= QUO_W; k++) begin : g_step
      always_comb begin
         logic [DMAG_W:0]   r2;
         logic [DMAG_W+1:0] diff;
         logic              ge;
         st_in[k] = st_ff[k-1];
         for (int i = 0; i < N_ELEM; i++) begin
            r2   = {st_ff[k-1].lane[i].rem, 1'b0};
            diff = {1'b0, r2} - {2'b00, st_ff[k-1].dmag};
            ge   = !diff[DMAG_W+1];
            st_in[k].lane[i].rem = ge ? diff[DMAG_W-1:0] : r2[DMAG_W-1:0];
            st_in[k].lane[i].quo = {st_ff[k-1].lane[i].quo[QUO_W-2:0], ge};
         end
      end
   end

   // Sign and saturation.
   always_comb begin
      logic [QUO_W:0] qf;
      lane_type       ln;
      sing_in = st_ff[QUO_W].singular;
      for (int i = 0; i < N_ELEM; i++) begin
         ln = st_ff[QUO_W].lane[i];
         qf = ln.ovf ? {1'b1, {QUO_W{1'b0}}} : {1'b0, ln.quo};
         if (st_ff[QUO_W].singular || ln.zero) begin
            out_in[i] = '0;
         end else if (ln.neg) begin
            if (qf > {1'b0, SAT_NEG}) begin
               out_in[i] = SAT_NEG;
            end else begin
               out_in[i] = QUO_W'({(QUO_W+1){1'b0}} - qf);
            end
         end else begin
            if (qf > {1'b0, SAT_POS}) begin
               out_in[i] = SAT_POS;
            end else begin
               out_in[i] = qf[QUO_W-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         out_vld_ff <= 1'b0;
      end else begin
         for (int k = 0; k <= QUO_W; k++) begin
            if (rdy[k]) begin
               vld_ff[k] <= vld_in[k];
            end
         end
         if (out_rdy) begin
            out_vld_ff <= out_vld_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k <= QUO_W; k++) begin
         if (rdy[k]) begin
            st_ff[k] <= st_in[k];
         end
      end
      if (out_rdy) begin
         out_ff <= out_in;
         sing_ff <= sing_in;
      end
   end

   assign rsp_chan.valid    = out_vld_ff;
   assign rsp_chan.v00      = out_ff[0];
   assign rsp_chan.v01      = out_ff[1];
   assign rsp_chan.v02      = out_ff[2];
   assign rsp_chan.v10      = out_ff[3];
   assign rsp_chan.v11      = out_ff[4];
   assign rsp_chan.v12      = out_ff[5];
   assign rsp_chan.v20      = out_ff[6];
   assign rsp_chan.v21      = out_ff[7];
   assign rsp_chan.v22      = out_ff[8];
   assign rsp_chan.singular = sing_ff;

endmodule

// File: src/matrix_inverse_3x3.sv
// Top level of the 3x3 Q16.16 matrix inverse (adjugate over determinant).
// Depends on mi3_pkg, mi3_req_if / mi3_rsp_if and the divider mi3_div.
//
//   channel   | direction | payload
//   ----------+-----------+-----------------------------------------------
//   req_chan  | in        | m00..m22, signed Q16.16 matrix elements
//   rsp_chan  | out       | v00..v22 inverse in Q16.16, singular flag
//
// One request enters per cycle while the pipeline is not stalled. A request
// passes 42 registers: eight stages for products, cofactors and determinant,
// one divider setup stage, 32 divider stages (one quotient bit each) and the
// saturating output register. The first is loaded at the accepting edge.
// Reset is synchronous and clears only valid bits.
// Every stage holds while the next one is full and stalled, and an empty stage
// always takes new data, so bubbles close up under back-pressure.
module matrix_inverse_3x3 (
   input  logic      clock,
   input  logic      reset,
   mi3_req_if.sink   req_chan,
   mi3_rsp_if.source rsp_chan
);
   import mi3_pkg::*;

   localparam int NSTG = 8;

   logic [NSTG:1] vld_ff, vld_in;
   logic [NSTG+1:1] rdy;

   // Stage 1: registered matrix.
   elem_type m1_ff [N_ELEM];
   elem_type m1_in [N_ELEM];
   // Stage 2: the two 32x32 products of every cofactor.
   logic signed [COF_W-1:0] p2a_ff [N_ELEM], p2b_ff [N_ELEM];
   logic signed [COF_W-1:0] p2a_in [N_ELEM], p2b_in [N_ELEM];
   elem_type m2_ff [N_TERM];
   // Stage 3: cofactors, wrapping to 64 bits.
   logic [COF_W-1:0] cof3_ff [N_ELEM], cof3_in [N_ELEM];
   elem_type m3_ff [N_TERM];
   // Stage 4: magnitudes and signs.
   logic [COF_W-1:0]  amag4_ff [N_ELEM], amag4_in [N_ELEM];
   logic [N_ELEM-1:0] aneg4_ff, aneg4_in, azero4_ff, azero4_in;
   logic [ELEM_W-1:0] mmag4_ff [N_TERM], mmag4_in [N_TERM];
   logic [N_TERM-1:0] tneg4_ff, tneg4_in;
   // Stage 5: 32x32 partial products of the determinant terms.
   logic [COF_W-1:0]  plo5_ff [N_TERM], phi5_ff [N_TERM];
   logic [COF_W-1:0]  plo5_in [N_TERM], phi5_in [N_TERM];
   logic [COF_W-1:0]  amag5_ff [N_ELEM];
   logic [N_ELEM-1:0] aneg5_ff, azero5_ff;
   logic [N_TERM-1:0] tneg5_ff;
   // Stage 6: term magnitudes.
   dmag_type          tmag6_ff [N_TERM], tmag6_in [N_TERM];
   logic [COF_W-1:0]  amag6_ff [N_ELEM];
   logic [N_ELEM-1:0] aneg6_ff, azero6_ff;
   logic [N_TERM-1:0] tneg6_ff;
   // Stage 7: signed determinant.
   logic [DET_W-1:0]  det7_ff, det7_in;
   logic [COF_W-1:0]  amag7_ff [N_ELEM];
   logic [N_ELEM-1:0] aneg7_ff, azero7_ff;
   // Stage 8: divisor magnitude and flags for the divider.
   div_in_type        s8_ff, s8_in;

   // Handshake chain: a stage moves when it is empty or its successor moves.
   always_comb begin
      for (int s = NSTG; s >= 1; s--) begin
         rdy[s] = !vld_ff[s] || rdy[s+1];
      end
      vld_in[1] = req_chan.valid;
      for (int s = 2; s <= NSTG; s++) begin
         vld_in[s] = vld_ff[s-1];
      end
   end
   assign req_chan.ready = rdy[1];

   always_comb begin
      m1_in[0] = req_chan.m00;
      m1_in[1] = req_chan.m01;
      m1_in[2] = req_chan.m02;
      m1_in[3] = req_chan.m10;
      m1_in[4] = req_chan.m11;
      m1_in[5] = req_chan.m12;
      m1_in[6] = req_chan.m20;
      m1_in[7] = req_chan.m21;
      m1_in[8] = req_chan.m22;
   end

   always_comb begin
      for (int i = 0; i < N_ELEM; i++) begin
         p2a_in[i] = COF_W'(m1_ff[COF_PA[i]]) * COF_W'(m1_ff[COF_PB[i]]);
         p2b_in[i] = COF_W'(m1_ff[COF_PC[i]]) * COF_W'(m1_ff[COF_PD[i]]);
         cof3_in[i] = p2a_ff[i] - p2b_ff[i];
         aneg4_in[i] = cof3_ff[i][COF_W-1];
         azero4_in[i] = cof3_ff[i] == '0;
         amag4_in[i] = aneg4_in[i] ? ({COF_W{1'b0}} - cof3_ff[i]) : cof3_ff[i];
      end
   end

   // Determinant expands along row 0: m0j times cofactor 3j.
   always_comb begin
      logic [ELEM_W-1:0] mu;
      logic [DET_W-1:0]  acc;
      for (int j = 0; j < N_TERM; j++) begin
         mu = m3_ff[j];
         mmag4_in[j] = mu[ELEM_W-1] ? ({ELEM_W{1'b0}} - mu) : mu;
         tneg4_in[j] = mu[ELEM_W-1] ^ cof3_ff[3*j][COF_W-1];
         plo5_in[j] = COF_W'(mmag4_ff[j]) * COF_W'(amag4_ff[3*j][ELEM_W-1:0]);
         phi5_in[j] = COF_W'(mmag4_ff[j]) * COF_W'(amag4_ff[3*j][COF_W-1:ELEM_W]);
         tmag6_in[j] = DMAG_W'(plo5_ff[j]) + {phi5_ff[j], {ELEM_W{1'b0}}};
      end
      // Conditional negation as inverted terms plus a count of carry-ins, so
      // the whole determinant is one multi-operand sum.
      acc = DET_W'(tneg6_ff[0]) + DET_W'(tneg6_ff[1]) + DET_W'(tneg6_ff[2]);
      for (int j = 0; j < N_TERM; j++) begin
         acc = acc + (DET_W'(tmag6_ff[j]) ^ {DET_W{tneg6_ff[j]}});
      end
      det7_in = acc;
   end

   always_comb begin
      logic [DET_W-1:0] dabs;
      dabs = det7_ff[DET_W-1] ? ({DET_W{1'b0}} - det7_ff) : det7_ff;
      s8_in.dmag = dabs[DMAG_W-1:0];
      s8_in.dneg = det7_ff[DET_W-1];
      s8_in.singular = det7_ff == '0;
      for (int i = 0; i < N_ELEM; i++) begin
         s8_in.amag[i] = amag7_ff[i];
      end
      s8_in.aneg = aneg7_ff;
      s8_in.azero = azero7_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int s = 1; s <= NSTG; s++) begin
            if (rdy[s]) begin
               vld_ff[s] <= vld_in[s];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[1]) begin
         m1_ff <= m1_in;
      end
      if (rdy[2]) begin
         p2a_ff <= p2a_in;
         p2b_ff <= p2b_in;
         for (int j = 0; j < N_TERM; j++) begin
            m2_ff[j] <= m1_ff[j];
         end
      end
      if (rdy[3]) begin
         cof3_ff <= cof3_in;
         m3_ff <= m2_ff;
      end
      if (rdy[4]) begin
         amag4_ff <= amag4_in;
         aneg4_ff <= aneg4_in;
         azero4_ff <= azero4_in;
         mmag4_ff <= mmag4_in;
         tneg4_ff <= tneg4_in;
      end
      if (rdy[5]) begin
         plo5_ff <= plo5_in;
         phi5_ff <= phi5_in;
         amag5_ff <= amag4_ff;
         aneg5_ff <= aneg4_ff;
         azero5_ff <= azero4_ff;
         tneg5_ff <= tneg4_ff;
      end
      if (rdy[6]) begin
         tmag6_ff <= tmag6_in;
         amag6_ff <= amag5_ff;
         aneg6_ff <= aneg5_ff;
         azero6_ff <= azero5_ff;
         tneg6_ff <= tneg5_ff;
      end
      if (rdy[7]) begin
         det7_ff <= det7_in;
         amag7_ff <= amag6_ff;
         aneg7_ff <= aneg6_ff;
         azero7_ff <= azero6_ff;
      end
      if (rdy[8]) begin
         s8_ff <= s8_in;
      end
   end

   mi3_div u_div (
      .clock    (clock),
      .reset    (reset),
      .in_valid (vld_ff[NSTG]),
      .in_ready (rdy[NSTG+1]),
      .in_data  (s8_ff),
      .rsp_chan (rsp_chan)
   );

endmodule

// File: src/mi3_checker.sv
// Port-level checks for matrix_inverse_3x3 and the bind that attaches them.
// Depends on mi3_pkg and the top level's channel interfaces.
module mi3_checker (
   input logic                                            clock,
   input logic                                            reset,
   input logic                                            rsp_valid,
   input logic                                            rsp_ready,
   input logic [mi3_pkg::N_ELEM*mi3_pkg::ELEM_W-1:0]       rsp_v,
   input logic                                            rsp_singular
);
   import mi3_pkg::*;

   // A stalled response keeps its request's values.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_v) && $stable(rsp_singular))
      else $error("response changed while stalled");

   // A singular matrix reports an all-zero inverse.
   a_sing_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_singular |-> rsp_v == '0)
      else $error("singular response with nonzero elements");

   // Reset empties the pipeline.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind matrix_inverse_3x3 mi3_checker u_mi3_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .rsp_v        ({rsp_chan.v22, rsp_chan.v21, rsp_chan.v20,
                   rsp_chan.v12, rsp_chan.v11, rsp_chan.v10,
                   rsp_chan.v02, rsp_chan.v01, rsp_chan.v00}),
   .rsp_singular (rsp_chan.singular)
);

// File: sim/matrix_inverse_3x3_tb.sv
`timescale 1ns / 100ps
// Testbench for matrix_inverse_3x3: drives matrices over the request channel and
// compares each response with an exact adjugate-over-determinant prediction.
// Depends on mi3_pkg, the mi3_req_if / mi3_rsp_if interfaces and the block RTL.
module matrix_inverse_3x3_tb;
   import mi3_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   mi3_req_if req_chan ();
   mi3_rsp_if rsp_chan ();

   matrix_inverse_3x3 u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source)
   );

   typedef struct {
      logic signed [31:0] v [9];
      logic               singular;
   } inverse_type;

   inverse_type inverse_queue [$];
   int  mismatch_count = 0;
   int  cycle_count    = 0;
   bit  hold_off       = 1'b0;
   bit  long_hold      = 1'b0;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int PIPE_LATENCY = 42;

   // One element of the inverse: cofactor * 2^32 / det, truncated toward zero
   // and saturated. The quotient is formed on magnitudes, so truncation toward
   // zero falls out of the unsigned division.
   function automatic logic signed [31:0] inverse_element(logic signed [63:0] cofactor,
                                                          logic signed [127:0] det);
      logic [127:0] num;
      logic [127:0] dmag;
      logic [127:0] q;
      bit           neg;
      if (cofactor == 0) return 32'sd0;
      neg  = (cofactor < 0) != (det < 0);
      num  = {64'd0, (cofactor < 0) ? -cofactor : cofactor} << 32;
      dmag = (det < 0) ? -det : det;
      q    = num / dmag;
      if (neg) begin
         if (q > 128'h8000_0000) q = 128'h8000_0000;
         return -$signed(q[31:0]);
      end
      if (q > 128'h7FFF_FFFF) q = 128'h7FFF_FFFF;
      return q[31:0];
   endfunction

   function automatic inverse_type predict_inverse(logic signed [31:0] m [9]);
      inverse_type         r;
      logic signed [63:0]  a [9];
      logic signed [127:0] det;
      a[0] = 64'(m[4]) * m[8] - 64'(m[5]) * m[7];
      a[1] = 64'(m[2]) * m[7] - 64'(m[1]) * m[8];
      a[2] = 64'(m[1]) * m[5] - 64'(m[2]) * m[4];
      a[3] = 64'(m[5]) * m[6] - 64'(m[3]) * m[8];
      a[4] = 64'(m[0]) * m[8] - 64'(m[2]) * m[6];
      a[5] = 64'(m[2]) * m[3] - 64'(m[0]) * m[5];
      a[6] = 64'(m[3]) * m[7] - 64'(m[4]) * m[6];
      a[7] = 64'(m[1]) * m[6] - 64'(m[0]) * m[7];
      a[8] = 64'(m[0]) * m[4] - 64'(m[1]) * m[3];
      det = 128'(m[0]) * 128'(a[0]) + 128'(m[1]) * 128'(a[3]) + 128'(m[2]) * 128'(a[6]);
      r.singular = (det == 0);
      for (int i = 0; i < 9; i++)
         r.v[i] = r.singular ? 32'sd0 : inverse_element(a[i], det);
      return r;
   endfunction

   // Mostly no gap at all, else a short one, now and then a long one.
   function automatic int random_gap();
      int p;
      p = $urandom_range(0, 99);
      if (p < 60) return 0;
      if (p < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // Sends one request at the falling edge and holds it until accepted. Valid
   // stays high across back-to-back requests, never dropped and raised in one step.
   task automatic send_matrix(logic signed [31:0] m [9], bit use_gaps = 1'b1);
      int gap;
      gap = use_gaps ? random_gap() : 0;
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid <= 1'b1;
      {req_chan.m00, req_chan.m01, req_chan.m02, req_chan.m10, req_chan.m11,
       req_chan.m12, req_chan.m20, req_chan.m21, req_chan.m22} <=
         {m[0], m[1], m[2], m[3], m[4], m[5], m[6], m[7], m[8]};
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      inverse_queue.push_back(predict_inverse(m));
      @(negedge clock);
   endtask

   task automatic idle_input();
      req_chan.valid <= 1'b0;
   endtask

   task automatic wait_drained();
      idle_input();
      while (inverse_queue.size() != 0) @(negedge clock);
   endtask

   function automatic logic signed [31:0] random_element();
      case ($urandom_range(0, 7))
         0: return 32'sh8000_0000;
         1: return 32'sh7FFF_FFFF;
         2: return 32'sd0;
         3: return $signed(32'($urandom_range(0, 32'h3_0000))) - 32'sh1_8000;
         4: return $signed(32'($urandom_range(0, 255))) - 32'sd128;
         default: return $signed($urandom());
      endcase
   endfunction

   // Directed corners: identity, scaled identity, extremes, singular
   // matrices, saturation in both directions and zero cofactors.
   task automatic test_directed();
      logic signed [31:0] m [9];
      m = '{32'sh1_0000, 0, 0, 0, 32'sh1_0000, 0, 0, 0, 32'sh1_0000};
      send_matrix(m);
      m = '{32'sh2_0000, 0, 0, 0, -32'sh4_0000, 0, 0, 0, 32'sh0_8000};
      send_matrix(m);
      m = '{0, 0, 0, 0, 0, 0, 0, 0, 0};
      send_matrix(m);
      m = '{32'sh1_0000, 32'sh2_0000, 32'sh3_0000, 32'sh2_0000, 32'sh4_0000,
            32'sh6_0000, 32'sh7_0000, 32'sh8_0000, 32'sh9_0000};
      send_matrix(m);
      m = '{1, 0, 0, 0, 1, 0, 0, 0, 1};
      send_matrix(m);
      m = '{-1, 0, 0, 0, 1, 0, 0, 0, -1};
      send_matrix(m);
      m = '{32'sh7FFF_FFFF, 0, 0, 0, 32'sh7FFF_FFFF, 0, 0, 0, 32'sh7FFF_FFFF};
      send_matrix(m);
      m = '{32'sh8000_0000, 0, 0, 0, 32'sh8000_0000, 0, 0, 0, 32'sh8000_0000};
      send_matrix(m);
      for (int i = 0; i < 9; i++) m[i] = 32'sh8000_0000;
      send_matrix(m);
      for (int i = 0; i < 9; i++) m[i] = 32'sh7FFF_FFFF;
      send_matrix(m);
      m = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000,
            32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
            32'sh8000_0000};
      send_matrix(m);
      m = '{32'sh8000_0000, 32'sh7FFF_FFFF, 0, 32'sh7FFF_FFFF, 32'sh8000_0000,
            0, 0, 0, -1};
      send_matrix(m);
      m = '{-32'sh1_0000, 32'sh0_0001, 0, 0, 32'sh1_0000, 0, 32'sh3_0000, 0,
            32'sh2_0000};
      send_matrix(m);
      m = '{0, 32'sh1_0000, 0, 0, 0, 32'sh1_0000, 32'sh1_0000, 0, 0};
      send_matrix(m);
      m = '{32'shFFFF_FFFF, 32'sh5555_5555, 32'shAAAA_AAAA, 32'sh1234_5678,
            32'shEDCB_A987, 32'sh0F0F_0F0F, 32'shF0F0_F0F0, 32'sh0000_FFFF,
            32'shFFFF_0000};
      send_matrix(m);
      wait_drained();
   endtask

   // Random matrices of mixed scale, with some rank-deficient ones mixed in.
   task automatic test_random(int count);
      logic signed [31:0] m [9];
      for (int n = 0; n < count; n++) begin
         for (int i = 0; i < 9; i++) m[i] = random_element();
         if ($urandom_range(0, 15) == 0) begin
            for (int c = 0; c < 3; c++) m[6 + c] = m[c];
         end
         send_matrix(m);
      end
   endtask

   // The receiver stops for a long stretch while requests keep coming, so the
   // pipeline fills and must stall its input; then the sender waits for all
   // outstanding responses.
   task automatic test_backpressure();
      logic signed [31:0] m [9];
      long_hold = 1'b1;
      for (int n = 0; n < 120; n++) begin
         for (int i = 0; i < 9; i++) m[i] = random_element();
         send_matrix(m, 1'b0);
      end
      wait_drained();
   endtask

   initial begin
      req_chan.valid = 1'b0;
      {req_chan.m00, req_chan.m01, req_chan.m02, req_chan.m10, req_chan.m11,
       req_chan.m12, req_chan.m20, req_chan.m21, req_chan.m22} = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_random(600);
      test_backpressure();
      test_random(620);
      wait_drained();
      repeat (PIPE_LATENCY + 10) @(negedge clock);
      if (mismatch_count == 0 && inverse_queue.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

   // Response ready: random stalls, plus one long hold counted here in cycles.
   initial begin
      int hold_len;
      int gap;
      rsp_chan.ready = 1'b0;
      @(negedge clock);
      forever begin
         if (long_hold) begin
            rsp_chan.ready <= 1'b0;
            for (hold_len = 0; hold_len < 300; hold_len++) @(negedge clock);
            long_hold = 1'b0;
         end
         gap = random_gap();
         if (gap > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_chan.ready <= 1'b1;
         @(negedge clock);
      end
   end

   // Response checker: each accepted response against the oldest prediction.
   always @(posedge clock) begin
      logic signed [31:0] got [9];
      inverse_type        want;
      bit                 bad;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got = '{rsp_chan.v00, rsp_chan.v01, rsp_chan.v02, rsp_chan.v10,
                 rsp_chan.v11, rsp_chan.v12, rsp_chan.v20, rsp_chan.v21,
                 rsp_chan.v22};
         if (inverse_queue.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("Unexpected response at cycle %0d", cycle_count);
         end else begin
            want = inverse_queue.pop_front();
            bad  = (rsp_chan.singular !== want.singular);
            for (int i = 0; i < 9; i++)
               if (got[i] !== want.v[i]) bad = 1'b1;
            if (bad) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("Mismatch at cycle %0d: singular exp %0b got %0b",
                           cycle_count, want.singular, rsp_chan.singular);
                  for (int i = 0; i < 9; i++)
                     if (got[i] !== want.v[i])
                        $display("  v%0d%0d exp %h got %h", i / 3, i % 3,
                                 want.v[i], got[i]);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

endmodule
